// ===== design/tccw_pkg.sv =====
// Package for the text console character writer.
// Holds default geometry, character codes, command codes and state encoding.
// No dependencies.
package tccw_pkg;

	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 8;

	// width that holds row*COLUMNS+column for any 5-bit row and 7-bit column
	localparam int WIDE_W = 13;

	localparam logic [15:0] BLANK_CELL = 16'h0F20;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_BLANK,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

// ===== design/text_console_character_writer_unit.sv =====
// Top level of the text console character writer: screen store, cursor and control.
// Depends on tccw_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------------
//  in      | input     | in_valid/in_ready  | command, char_code, bg_color, fg_color,
//          |           |                    | read_row, read_column
//  out     | output    | out_valid/out_ready| cursor_row, cursor_column, cursor_location,
//          |           |                    | cell_data
//
// Put without scroll passes through ST_DONE to the out registers; read passes ST_READ, ST_DONE.
// Scroll copies rows up through the single-port-write screen store, then blanks the last row.
// Clear fills the store one cell a cycle.
// After reset the store is filled blank; in_ready stays low until the fill is done.
// A new item is taken while a finished result still waits on out.
module text_console_character_writer_unit #(
	parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tccw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  char_code,
	input  logic [3:0]  bg_color,
	input  logic [3:0]  fg_color,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_column,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_column,
	output logic [10:0] cursor_location,
	output logic [15:0] cell_data
);

	localparam int CELL_N = COLUMNS * ROWS;
	localparam int COPY_N = COLUMNS * (ROWS - 1);
	localparam int ADDR_W = $clog2(CELL_N);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int NC_W   = $clog2(COLUMNS + TAB_STOP + 1);
	localparam int NR_W   = ROW_W + 1;
	localparam int KMAX   = COLUMNS / TAB_STOP + 1;
	localparam int WIDE_W = tccw_pkg::WIDE_W;

	localparam logic [ADDR_W-1:0] LAST      = ADDR_W'(CELL_N - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COPY_N - 1);

	tccw_pkg::state_t state_q, state_nx;

	logic [ADDR_W-1:0] cnt_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              rd_ok_q;
	logic [15:0]       cell_q;
	logic              out_valid_q;

	logic              cp_vld_s1;
	logic [ADDR_W-1:0] cp_addr_s1;

	logic [15:0]       mem [CELL_N];
	logic [15:0]       rd_q;

	logic              acc;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [15:0]       mem_wd;
	logic [ADDR_W-1:0] mem_ra;
	logic              out_load;

	logic [NC_W-1:0]   tab_col;
	logic [NC_W-1:0]   nc;
	logic [NR_W-1:0]   nr;
	logic              put_we;
	logic              scroll;
	logic [WIDE_W-1:0] cur_lin;
	logic [WIDE_W-1:0] rd_lin;
	logic              rd_ok;

	assign acc     = in_valid && in_ready;
	assign cur_lin = WIDE_W'(row_q) * WIDE_W'(COLUMNS) + WIDE_W'(col_q);
	assign rd_lin  = WIDE_W'(read_row) * WIDE_W'(COLUMNS) + WIDE_W'(read_column);
	assign rd_ok   = (int'(read_row) < ROWS) && (int'(read_column) < COLUMNS);

	// next tab stop above the current column
	always_comb begin
		tab_col = NC_W'(KMAX * TAB_STOP);
		for (int k = KMAX; k >= 1; k--) begin
			if (NC_W'(k * TAB_STOP) > NC_W'(col_q))
				tab_col = NC_W'(k * TAB_STOP);
		end
	end

	always_comb begin
		nc     = NC_W'(col_q);
		nr     = NR_W'(row_q);
		put_we = 1'b0;
		case (char_code)
			tccw_pkg::CH_BS: begin
				if (col_q != '0)
					nc = NC_W'(col_q) - NC_W'(1);
			end
			tccw_pkg::CH_TAB: nc = tab_col;
			tccw_pkg::CH_CR:  nc = '0;
			tccw_pkg::CH_LF: begin
				nc = '0;
				nr = NR_W'(row_q) + NR_W'(1);
			end
			default: begin
				if (char_code >= tccw_pkg::CH_SPACE && char_code <= tccw_pkg::CH_DEL) begin
					put_we = 1'b1;
					nc     = NC_W'(col_q) + NC_W'(1);
				end
			end
		endcase
		if (nc >= NC_W'(COLUMNS)) begin
			nc = '0;
			nr = nr + NR_W'(1);
		end
		scroll = (nr >= NR_W'(ROWS));
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			tccw_pkg::ST_INIT: begin
				if (cnt_q == LAST)
					state_nx = tccw_pkg::ST_IDLE;
			end
			tccw_pkg::ST_IDLE: begin
				if (acc) begin
					case (command)
						tccw_pkg::CMD_PUT:
							state_nx = scroll ? tccw_pkg::ST_COPY : tccw_pkg::ST_DONE;
						tccw_pkg::CMD_CLEAR: state_nx = tccw_pkg::ST_CLEAR;
						tccw_pkg::CMD_READ:  state_nx = tccw_pkg::ST_READ;
						default:             state_nx = tccw_pkg::ST_DONE;
					endcase
				end
			end
			tccw_pkg::ST_READ: state_nx = tccw_pkg::ST_DONE;
			tccw_pkg::ST_COPY: begin
				if (cnt_q == COPY_LAST)
					state_nx = tccw_pkg::ST_BLANK;
			end
			tccw_pkg::ST_BLANK: begin
				if (!cp_vld_s1 && cnt_q == LAST)
					state_nx = tccw_pkg::ST_DONE;
			end
			tccw_pkg::ST_CLEAR: begin
				if (cnt_q == LAST)
					state_nx = tccw_pkg::ST_DONE;
			end
			tccw_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready)
					state_nx = tccw_pkg::ST_IDLE;
			end
			default: state_nx = tccw_pkg::ST_INIT;
		endcase
	end

	// outputs and store access
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = cnt_q;
		mem_wd   = tccw_pkg::BLANK_CELL;
		mem_ra   = '0;
		case (state_q)
			tccw_pkg::ST_INIT, tccw_pkg::ST_CLEAR: mem_we = 1'b1;
			tccw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				mem_ra   = rd_ok ? ADDR_W'(rd_lin) : '0;
				if (acc && command == tccw_pkg::CMD_PUT && put_we) begin
					mem_we = 1'b1;
					mem_wa = ADDR_W'(cur_lin);
					mem_wd = {bg_color, fg_color, char_code};
				end
			end
			tccw_pkg::ST_COPY:  mem_ra = cnt_q + ADDR_W'(COLUMNS);
			tccw_pkg::ST_BLANK: mem_we = !cp_vld_s1;
			tccw_pkg::ST_DONE:  out_load = !out_valid_q || out_ready;
			default: ;
		endcase
		// hold off the blank fill until the last copied cell is written
		if (cp_vld_s1) begin
			mem_we = 1'b1;
			mem_wa = cp_addr_s1;
			mem_wd = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tccw_pkg::ST_INIT;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			cp_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			cp_vld_s1 <= (state_q == tccw_pkg::ST_COPY);
			case (state_q)
				tccw_pkg::ST_INIT, tccw_pkg::ST_CLEAR:
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + ADDR_W'(1);
				tccw_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (acc && command == tccw_pkg::CMD_PUT) begin
						col_q <= nc[COL_W-1:0];
						row_q <= scroll ? ROW_W'(ROWS - 1) : nr[ROW_W-1:0];
					end else if (acc && command == tccw_pkg::CMD_CLEAR) begin
						col_q <= '0;
						row_q <= '0;
					end
				end
				tccw_pkg::ST_COPY:
					cnt_q <= (cnt_q == COPY_LAST) ? ADDR_W'(COPY_N) : cnt_q + ADDR_W'(1);
				tccw_pkg::ST_BLANK: begin
					if (!cp_vld_s1)
						cnt_q <= cnt_q + ADDR_W'(1);
				end
				default: ;
			endcase
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= cnt_q;
		if (acc) begin
			rd_ok_q <= rd_ok && command == tccw_pkg::CMD_READ;
			cell_q  <= '0;
		end else if (state_q == tccw_pkg::ST_READ) begin
			cell_q <= rd_ok_q ? rd_q : '0;
		end
		if (out_load) begin
			cursor_row      <= 5'(row_q);
			cursor_column   <= 7'(col_q);
			cursor_location <= cur_lin[10:0];
			cell_data       <= cell_q;
		end
	end

	assign out_valid = out_valid_q;

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(row_q) < ROWS) && (int'(col_q) < COLUMNS))
		else $error("cursor out of screen");

	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccw_pkg::ST_IDLE && mem_we) |-> (acc && command == tccw_pkg::CMD_PUT))
		else $error("store write in idle without put transfer");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tccw_pkg::ST_DONE))
		else $error("result raised outside done");

	a_copy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> (state_q == tccw_pkg::ST_COPY || state_q == tccw_pkg::ST_BLANK))
		else $error("copy write outside scroll");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccw_pkg::ST_COPY) |-> (int'(row_q) == ROWS - 1))
		else $error("scroll with cursor off last row");

endmodule

// ===== verif/tccw_result_checker.sv =====
// Result checker for the text console character writer.
// Tracks screen and cursor from accepted input transfers and compares every output transfer.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  char_code,
	input  logic [3:0]  bg_color,
	input  logic [3:0]  fg_color,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_column,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  cursor_row,
	input  logic [6:0]  cursor_column,
	input  logic [10:0] cursor_location,
	input  logic [15:0] cell_data,
	output int          mismatch_count,
	output int          pending_count
);

	localparam int COLS  = tccw_pkg::COLUMNS_DEF;
	localparam int LINES = tccw_pkg::ROWS_DEF;
	localparam int TAB   = tccw_pkg::TAB_STOP_DEF;
	localparam int CELLS = COLS * LINES;

	typedef struct packed {
		logic [4:0]  row;
		logic [6:0]  col;
		logic [10:0] loc;
		logic [15:0] data;
	} cursor_report_t;

	logic [15:0]    screen_model [CELLS];
	int             cur_row;
	int             cur_col;
	int             result_index;
	cursor_report_t expected_reports [$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] result %0d: %s", $realtime, result_index, msg);
		mismatch_count = mismatch_count + 1;
	endtask

	task automatic blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen_model[i] = tccw_pkg::BLANK_CELL;
		cur_row = 0;
		cur_col = 0;
	endtask

	task automatic predict_transfer(
		input  logic [1:0]     cmd,
		input  logic [7:0]     code,
		input  logic [3:0]     bc,
		input  logic [3:0]     fc,
		input  logic [4:0]     rr,
		input  logic [6:0]     rc,
		output cursor_report_t rep
	);
		logic [15:0] read_word;
		read_word = '0;
		case (cmd)
		tccw_pkg::CMD_PUT: begin
			if (code == tccw_pkg::CH_BS) begin
				if (cur_col != 0)
					cur_col = cur_col - 1;
			end else if (code == tccw_pkg::CH_TAB) begin
				cur_col = (cur_col / TAB + 1) * TAB;
			end else if (code == tccw_pkg::CH_CR) begin
				cur_col = 0;
			end else if (code == tccw_pkg::CH_LF) begin
				cur_col = 0;
				cur_row = cur_row + 1;
			end else if (code >= tccw_pkg::CH_SPACE && code <= tccw_pkg::CH_DEL) begin
				screen_model[cur_row * COLS + cur_col] = {bc, fc, code};
				cur_col = cur_col + 1;
			end
			if (cur_col >= COLS) begin
				cur_col = 0;
				cur_row = cur_row + 1;
			end
			if (cur_row >= LINES) begin
				for (int i = 0; i < CELLS - COLS; i++)
					screen_model[i] = screen_model[i + COLS];
				for (int i = CELLS - COLS; i < CELLS; i++)
					screen_model[i] = tccw_pkg::BLANK_CELL;
				cur_row = LINES - 1;
			end
		end
		tccw_pkg::CMD_CLEAR: blank_screen();
		tccw_pkg::CMD_READ: begin
			if (rr < LINES && rc < COLS)
				read_word = screen_model[rr * COLS + rc];
		end
		default: ;
		endcase
		rep.row  = 5'(cur_row);
		rep.col  = 7'(cur_col);
		rep.loc  = 11'(cur_row * COLS + cur_col);
		rep.data = read_word;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cursor_report_t exp_rep;
		cursor_report_t new_rep;
		if (!arst_n) begin
			blank_screen();
			expected_reports.delete();
			mismatch_count = 0;
			pending_count = 0;
			result_index = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("output transfer with no input transfer pending");
				end else begin
					exp_rep = expected_reports.pop_front();
					if (cursor_row !== exp_rep.row)
						report_mismatch($sformatf("cursor_row got %0d, expected %0d",
							cursor_row, exp_rep.row));
					if (cursor_column !== exp_rep.col)
						report_mismatch($sformatf("cursor_column got %0d, expected %0d",
							cursor_column, exp_rep.col));
					if (cursor_location !== exp_rep.loc)
						report_mismatch($sformatf("cursor_location got %0d, expected %0d",
							cursor_location, exp_rep.loc));
					if (cell_data !== exp_rep.data)
						report_mismatch($sformatf("cell_data got %h, expected %h",
							cell_data, exp_rep.data));
				end
				result_index = result_index + 1;
			end
			if (in_valid && in_ready) begin
				predict_transfer(command, char_code, bg_color, fg_color,
					read_row, read_column, new_rep);
				expected_reports.push_back(new_rep);
			end
			pending_count = expected_reports.size();
		end
	end

endmodule

// ===== verif/tb_text_console_character_writer_unit.sv =====
// Testbench top for the text console character writer unit.
// Drives directed and random transfers with bursty input and stalling output; uses tccw_result_checker.
// Depends on tccw_pkg, text_console_character_writer_unit and tccw_result_checker.
`timescale 1ns / 1ps

module tb_text_console_character_writer_unit;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int HOLD_AT        = 400;
	localparam int LONG_HOLD      = 800;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 50;

	typedef enum {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = '0;
	logic [7:0]  char_code = '0;
	logic [3:0]  bg_color = '0;
	logic [3:0]  fg_color = '0;
	logic [4:0]  read_row = '0;
	logic [6:0]  read_column = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_column;
	logic [10:0] cursor_location;
	logic [15:0] cell_data;
	int          mismatch_count;
	int          pending_count;

	int          items_sent = 0;
	int          burst_left = 0;
	int          hold_left = 0;
	bit          long_hold_done = 1'b0;
	int unsigned stall_cycle = 0;
	ready_mode_t stall_mode = READY_ALWAYS;
	int          idle_cycles = 0;

	always #1 clk = ~clk;

	text_console_character_writer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.char_code      (char_code),
		.bg_color       (bg_color),
		.fg_color       (fg_color),
		.read_row       (read_row),
		.read_column    (read_column),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cursor_row     (cursor_row),
		.cursor_column  (cursor_column),
		.cursor_location(cursor_location),
		.cell_data      (cell_data)
	);

	tccw_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.char_code      (char_code),
		.bg_color       (bg_color),
		.fg_color       (fg_color),
		.read_row       (read_row),
		.read_column    (read_column),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cursor_row     (cursor_row),
		.cursor_column  (cursor_column),
		.cursor_location(cursor_location),
		.cell_data      (cell_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// offer one transfer at a falling edge; return at a falling edge after acceptance and any burst gap
	task automatic offer_item(
		input logic [1:0] cmd,
		input logic [7:0] code,
		input logic [3:0] bc,
		input logic [3:0] fc,
		input logic [4:0] rr,
		input logic [6:0] rc
	);
		int gap;
		in_valid    <= 1'b1;
		command     <= cmd;
		char_code   <= code;
		bg_color    <= bc;
		fg_color    <= fc;
		read_row    <= rr;
		read_column <= rc;
		do @(posedge clk); while (!in_ready);
		items_sent = items_sent + 1;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left = burst_left - 1;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// receiver: stall pattern by mode, plus one long hold-off to back up the block
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (!long_hold_done && items_sent >= HOLD_AT) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			stall_cycle = stall_cycle + 1;
			if (stall_cycle % 128 == 0)
				stall_mode = ready_mode_t'($urandom_range(0, 2));
			case (stall_mode)
			READY_ALWAYS: out_ready <= 1'b1;
			READY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
			default:      out_ready <= (stall_cycle % 4 == 0);
			endcase
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int          pick;
		logic [1:0]  cmd;
		logic [7:0]  code;
		logic [3:0]  bc;
		logic [3:0]  fc;
		logic [4:0]  rr;
		logic [6:0]  rc;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer_item(tccw_pkg::CMD_READ, 8'($urandom), 4'($urandom), 4'($urandom), 5'd0, 7'd0);
		offer_item(tccw_pkg::CMD_PUT, 8'h41, 4'h0, 4'h0, 5'($urandom), 7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, tccw_pkg::CH_DEL, 4'hF, 4'hF, 5'($urandom),
			7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, tccw_pkg::CH_SPACE, 4'hA, 4'h5, 5'($urandom),
			7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, tccw_pkg::CH_BS, 4'($urandom), 4'($urandom),
			5'($urandom), 7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 4'($urandom), 4'($urandom),
			5'($urandom), 7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, tccw_pkg::CH_CR, 4'($urandom), 4'($urandom),
			5'($urandom), 7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, tccw_pkg::CH_BS, 4'($urandom), 4'($urandom),
			5'($urandom), 7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, tccw_pkg::CH_LF, 4'($urandom), 4'($urandom),
			5'($urandom), 7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, 8'h00, 4'($urandom), 4'($urandom),
			5'($urandom), 7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, 8'h1F, 4'($urandom), 4'($urandom),
			5'($urandom), 7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, 8'h80, 4'($urandom), 4'($urandom),
			5'($urandom), 7'($urandom));
		offer_item(tccw_pkg::CMD_PUT, 8'hFF, 4'($urandom), 4'($urandom),
			5'($urandom), 7'($urandom));
		offer_item(tccw_pkg::CMD_READ, 8'($urandom), 4'($urandom), 4'($urandom), 5'd0, 7'd1);
		offer_item(tccw_pkg::CMD_READ, 8'($urandom), 4'($urandom), 4'($urandom), 5'd25, 7'd0);
		offer_item(tccw_pkg::CMD_READ, 8'($urandom), 4'($urandom), 4'($urandom), 5'd31,
			7'd127);
		offer_item(tccw_pkg::CMD_READ, 8'($urandom), 4'($urandom), 4'($urandom), 5'd0, 7'd80);
		offer_item(CMD_UNUSED, 8'($urandom), 4'($urandom), 4'($urandom), 5'($urandom),
			7'($urandom));
		offer_item(tccw_pkg::CMD_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom),
			5'($urandom), 7'($urandom));
		// tab past the right edge wraps to the next row
		repeat (tccw_pkg::COLUMNS_DEF / tccw_pkg::TAB_STOP_DEF)
			offer_item(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 4'($urandom), 4'($urandom),
				5'($urandom), 7'($urandom));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			cmd  = tccw_pkg::CMD_PUT;
			code = 8'($urandom);
			bc   = 4'($urandom);
			fc   = 4'($urandom);
			rr   = 5'($urandom);
			rc   = 7'($urandom);
			if (pick < 55) begin
				code = 8'($urandom_range(tccw_pkg::CH_SPACE, tccw_pkg::CH_DEL));
			end else if (pick < 63) begin
				code = tccw_pkg::CH_LF;
			end else if (pick < 67) begin
				code = tccw_pkg::CH_CR;
			end else if (pick < 71) begin
				code = tccw_pkg::CH_TAB;
			end else if (pick < 75) begin
				code = tccw_pkg::CH_BS;
			end else if (pick < 79) begin
				code = 8'($urandom);
			end else if (pick < 98) begin
				cmd = tccw_pkg::CMD_READ;
				if ($urandom_range(0, 9) != 0) begin
					rr = 5'($urandom_range(0, tccw_pkg::ROWS_DEF - 1));
					rc = 7'($urandom_range(0, tccw_pkg::COLUMNS_DEF - 1));
				end
			end else if (pick < 99) begin
				cmd = tccw_pkg::CMD_CLEAR;
			end else begin
				cmd = CMD_UNUSED;
			end
			offer_item(cmd, code, bc, fc, rr, rc);
		end

		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
design/tccw_pkg.sv
design/text_console_character_writer_unit.sv
verif/tccw_result_checker.sv
verif/tb_text_console_character_writer_unit.sv
